FILE: sv/rmsp_pkg.sv
// Shared types and constants of the RMSProp weight update unit.
`default_nettype none
package rmsp_pkg;
  localparam int unsigned IdxW = 10;
  localparam int unsigned DataW = 32;
  localparam int unsigned LrW = 24;
  localparam int unsigned DiscW = 17;
  localparam int unsigned EpsW = 16;
  localparam logic [31:0] MsOne = 32'd65536;

  // Configuration register indexes
  localparam logic [1:0] RegLr = 2'd0;
  localparam logic [1:0] RegDisc = 2'd1;
  localparam logic [1:0] RegEps = 2'd2;

  // Bits of the square-root operand (ms' << 16) and of its root
  localparam int unsigned SqW = 48;
  localparam int unsigned RootW = 24;

  // Divider: 56-bit dividend (lr * |g|), 25-bit denominator
  localparam int unsigned NumW = 56;
  localparam int unsigned DenW = 25;

  // Item context carried alongside the arithmetic
  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [DataW-1:0] weight;
    logic neg;
    logic sat;
  } ctx_t;
endpackage
`default_nettype wire

FILE: sv/rmsp_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
`default_nettype none
module rmsp_sqrt #(
  parameter int unsigned TagW = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            valid_i,
  input  wire logic [rmsp_pkg::SqW-1:0]        rad_i,
  input  wire logic [TagW-1:0]                 tag_i,
  output logic                                 valid_o,
  output logic [rmsp_pkg::RootW-1:0]           root_o,
  output logic [TagW-1:0]                      tag_o
);
  localparam int unsigned N = rmsp_pkg::RootW;
  localparam int unsigned W = rmsp_pkg::SqW;
  localparam int unsigned RemW = N + 2;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic            vld_c;
    logic [W-1:0]    rad_c;
    logic [RemW-1:0] rem_c;
    logic [N-1:0]    res_c;
    logic [TagW-1:0] tag_c;
    logic [RemW-1:0] trial;
    logic [RemW-1:0] shifted;
    logic            vld_q;
    logic [W-1:0]    rad_q;
    logic [RemW-1:0] rem_q;
    logic [N-1:0]    res_q;
    logic [TagW-1:0] tag_q;

    // stage operands: unit inputs or the previous stage
    if (s == 0) begin : g_head
      assign vld_c = valid_i;
      assign rad_c = rad_i;
      assign rem_c = '0;
      assign res_c = '0;
      assign tag_c = tag_i;
    end else begin : g_link
      assign vld_c = g_stage[s-1].vld_q;
      assign rad_c = g_stage[s-1].rad_q;
      assign rem_c = g_stage[s-1].rem_q;
      assign res_c = g_stage[s-1].res_q;
      assign tag_c = g_stage[s-1].tag_q;
    end

    // bring down two radicand bits, try subtracting 4*res+1
    assign shifted = {rem_c[RemW-3:0], rad_c[W-1:W-2]};
    assign trial = shifted - {res_c, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q <= {rad_c[W-3:0], 2'b00};
        tag_q <= tag_c;
        if (!trial[RemW-1]) begin
          rem_q <= trial;
          res_q <= {res_c[N-2:0], 1'b1};
        end else begin
          rem_q <= shifted;
          res_q <= {res_c[N-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = g_stage[N-1].vld_q;
  assign root_o = g_stage[N-1].res_q;
  assign tag_o = g_stage[N-1].tag_q;
endmodule
`default_nettype wire

FILE: sv/rmsp_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
`default_nettype none
module rmsp_div #(
  parameter int unsigned TagW = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [rmsp_pkg::NumW-1:0]    num_i,
  input  wire logic [rmsp_pkg::DenW-1:0]    den_i,
  input  wire logic [TagW-1:0]              tag_i,
  output logic                              valid_o,
  output logic [rmsp_pkg::NumW-1:0]         quo_o,
  output logic [TagW-1:0]                   tag_o
);
  localparam int unsigned N = rmsp_pkg::NumW;
  localparam int unsigned D = rmsp_pkg::DenW;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic            vld_c;
    logic [N-1:0]    num_c;
    logic [D-1:0]    rem_c;
    logic [D-1:0]    den_c;
    logic [TagW-1:0] tag_c;
    logic [D:0]      shifted;
    logic [D:0]      diff;
    logic            vld_q;
    logic [N-1:0]    num_q;
    logic [D-1:0]    rem_q;
    logic [D-1:0]    den_q;
    logic [TagW-1:0] tag_q;

    // stage operands: unit inputs or the previous stage
    if (s == 0) begin : g_head
      assign vld_c = valid_i;
      assign num_c = num_i;
      assign rem_c = '0;
      assign den_c = den_i;
      assign tag_c = tag_i;
    end else begin : g_link
      assign vld_c = g_stage[s-1].vld_q;
      assign num_c = g_stage[s-1].num_q;
      assign rem_c = g_stage[s-1].rem_q;
      assign den_c = g_stage[s-1].den_q;
      assign tag_c = g_stage[s-1].tag_q;
    end

    // num shifts quotient bits in from the bottom
    assign shifted = {rem_c, num_c[N-1]};
    assign diff = shifted - {1'b0, den_c};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q <= den_c;
        tag_q <= tag_c;
        if (!diff[D]) begin
          rem_q <= diff[D-1:0];
          num_q <= {num_c[N-2:0], 1'b1};
        end else begin
          rem_q <= shifted[D-1:0];
          num_q <= {num_c[N-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = g_stage[N-1].vld_q;
  assign quo_o = g_stage[N-1].num_q;
  assign tag_o = g_stage[N-1].tag_q;
endmodule
`default_nettype wire

FILE: sv/rmsprop_weight_update_unit.sv
// Top level of the RMSProp weight update unit.
//
//  channel   dir  signals                        content
//  s_axis    in   tvalid tready tdata            index, gradient, weight
//  m_axis    out  tvalid tready tdata tuser      index, new weight / saturated
//  cfg       in   cfg_valid cfg_ready index data register write
//
// One item per cycle sustained while m_axis takes results; the path to m_axis runs
// through the 24-stage square root and the 56-stage divider.
// A read/update/write on the mean-square memory spans stages 1 to 3 and
// back-to-back hits on one element are forwarded. After reset a 1 entry/cycle
// clearing pass writes 1.0 to every entry; s_axis_tready stays low meanwhile.
// The whole pipe advances when the output register is free or being taken.
`default_nettype none
module rmsprop_weight_update_unit #(
  parameter int unsigned NUM_ELEMENTS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [9:0] element_index, [41:10] gradient, [73:42] weight, zero fill
  input  wire logic [79:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [9:0] result_index, [41:10] new_weight, zero fill
  output logic [47:0]      m_axis_tdata,
  // [0] saturated
  output logic [0:0]       m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  localparam int unsigned AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(NUM_ELEMENTS + 1);
  localparam int unsigned CtxW = $bits(rmsp_pkg::ctx_t);

  // configuration
  logic [rmsp_pkg::LrW-1:0]   lr_q;
  logic [rmsp_pkg::DiscW-1:0] disc_q;
  logic [rmsp_pkg::EpsW-1:0]  eps_q;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= 24'd655;
      disc_q <= 17'd58982;
      eps_q <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        rmsp_pkg::RegLr: lr_q <= cfg_data;
        rmsp_pkg::RegDisc: disc_q <= cfg_data[rmsp_pkg::DiscW-1:0];
        rmsp_pkg::RegEps: eps_q <= cfg_data[rmsp_pkg::EpsW-1:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic out_vld_q;
  logic en;
  assign en = !out_vld_q || m_axis_tready;

  // clearing pass
  logic [CW-1:0] clr_q;
  logic clearing;
  assign clearing = (clr_q != CW'(NUM_ELEMENTS));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (clearing) clr_q <= clr_q + 1'b1;
  end
  assign s_axis_tready = en && !clearing;

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // stage 1: capture, memory read issue, |g|
  logic [9:0]  in_idx;
  logic [31:0] in_g, in_w;
  assign in_idx = s_axis_tdata[9:0];
  assign in_g = s_axis_tdata[41:10];
  assign in_w = s_axis_tdata[73:42];

  logic [31:0] mem [NUM_ELEMENTS];
  logic [31:0] rd_q;
  logic        v1_q, st1_q, neg1_q;
  logic [9:0]  idx1_q;
  logic [AW-1:0] a1_q;
  logic [31:0] mag1_q, w1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      idx1_q <= in_idx;
      a1_q <= AW'(in_idx);
      st1_q <= {22'd0, in_idx} < 32'(NUM_ELEMENTS);
      neg1_q <= in_g[31];
      mag1_q <= in_g[31] ? (32'd0 - in_g) : in_g;
      w1_q <= in_w;
      rd_q <= mem[AW'(in_idx)];
    end
  end

  // stage 2: g squared; old ms with forwarding from later stages
  logic        v2_q, st2_q, neg2_q;
  logic [9:0]  idx2_q;
  logic [AW-1:0] a2_q;
  logic [31:0] mag2_q, w2_q;
  logic [63:0] gg2_q;
  logic [31:0] ms2_q;

  // write-back stage 3 results
  logic        v3, st3, wr3;
  logic [AW-1:0] a3;
  logic [31:0] msn3;

  logic        v4_q, st4_q;
  logic [AW-1:0] a4_q;
  logic [31:0] ms4_q;

  logic [31:0] old1;
  always_comb begin
    old1 = rd_q;
    if (v4_q && st4_q && a4_q == a1_q && en) old1 = ms4_q;
    if (wr3 && a3 == a1_q) old1 = msn3;
    if (!st1_q) old1 = rmsp_pkg::MsOne;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      idx2_q <= idx1_q; a2_q <= a1_q; st2_q <= st1_q; neg2_q <= neg1_q;
      mag2_q <= mag1_q; w2_q <= w1_q;
      gg2_q <= mag1_q * mag1_q;
      ms2_q <= old1;
    end else if (wr3 && a3 == a2_q && st2_q) begin
      ms2_q <= msn3;
    end
  end

  // stage 3: mean-square blend, saturate, write back
  logic [16:0] d2;
  logic [47:0] gsq;
  logic [48:0] p_old;
  logic [65:0] p_new;
  logic [66:0] sum;
  logic [50:0] shr;
  logic        sat3;
  logic        v3n;
  assign d2 = (disc_q > 17'd65536) ? 17'd65536 : disc_q;
  assign gsq = gg2_q[63:16];
  assign p_old = d2 * ms2_q;
  assign p_new = (17'd65536 - d2) * gsq;
  assign sum = {18'd0, p_old} + {1'b0, p_new};
  assign shr = sum[66:16];
  assign sat3 = |shr[50:32];
  assign msn3 = sat3 ? 32'hFFFF_FFFF : shr[31:0];
  assign v3n = v2_q;
  assign v3 = v3n;
  assign st3 = st2_q;
  assign a3 = a2_q;
  assign wr3 = v3 && st3 && en;

  always_ff @(posedge clk_i) begin
    if (clearing) mem[clr_q[AW-1:0]] <= rmsp_pkg::MsOne;
    else if (wr3) mem[a3] <= msn3;
  end

  // stage 4: registered ms' and context into the root unit
  logic        neg4_q, sat4_q;
  logic [9:0]  idx4_q;
  logic [31:0] mag4_q, w4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      st4_q <= st2_q; a4_q <= a2_q; ms4_q <= msn3; sat4_q <= sat3;
      idx4_q <= idx2_q; neg4_q <= neg2_q; mag4_q <= mag2_q; w4_q <= w2_q;
    end
  end

  // square root of ms' << 16
  localparam int unsigned STagW = CtxW + 32;
  rmsp_pkg::ctx_t ctx4, ctx5;
  logic [31:0] mag5;
  logic        v5;
  logic [rmsp_pkg::RootW-1:0] root5;
  logic [STagW-1:0] stag5;
  assign ctx4 = '{index: idx4_q, weight: w4_q, neg: neg4_q, sat: sat4_q};

  rmsp_sqrt #(.TagW(STagW)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q),
    .rad_i({ms4_q, 16'd0}), .tag_i({ctx4, mag4_q}),
    .valid_o(v5), .root_o(root5), .tag_o(stag5)
  );
  assign ctx5 = stag5[STagW-1:32];
  assign mag5 = stag5[31:0];

  // stage 6: denominator and numerator product
  logic        v6_q;
  rmsp_pkg::ctx_t ctx6_q;
  logic [rmsp_pkg::DenW-1:0] den6_q;
  logic [rmsp_pkg::NumW-1:0] num6_q;
  logic [rmsp_pkg::DenW-1:0] den5;
  assign den5 = {1'b0, root5} + {9'd0, eps_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx6_q <= ctx5;
      den6_q <= (den5 == '0) ? rmsp_pkg::DenW'(1) : den5;
      num6_q <= lr_q * mag5;
    end
  end

  // divide
  logic v7;
  logic [rmsp_pkg::NumW-1:0] quo7;
  logic [CtxW-1:0] tag7;
  rmsp_pkg::ctx_t ctx7;
  rmsp_div #(.TagW(CtxW)) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q),
    .num_i(num6_q), .den_i(den6_q), .tag_i(ctx6_q),
    .valid_o(v7), .quo_o(quo7), .tag_o(tag7)
  );
  assign ctx7 = tag7;

  // final: apply step, saturate, output register
  logic signed [57:0] w7, q7, nw7;
  logic        sat7;
  logic [31:0] res7;
  assign w7 = 58'(signed'(ctx7.weight));
  assign q7 = signed'({2'b00, quo7});
  assign nw7 = ctx7.neg ? (w7 + q7) : (w7 - q7);
  always_comb begin
    sat7 = ctx7.sat;
    res7 = nw7[31:0];
    if (nw7 > 58'sd2147483647) begin
      res7 = 32'h7FFF_FFFF; sat7 = 1'b1;
    end else if (nw7 < -58'sd2147483648) begin
      res7 = 32'h8000_0000; sat7 = 1'b1;
    end
  end

  logic [9:0]  oidx_q;
  logic [31:0] ow_q;
  logic        osat_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= v7;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      oidx_q <= ctx7.index; ow_q <= res7; osat_q <= sat7;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {6'd0, ow_q, oidx_q};
  assign m_axis_tuser = osat_q;
endmodule
`default_nettype wire

FILE: tb/sv/rmsprop_weight_update_unit_test.sv
// Testbench of the RMSProp weight update unit: stream stimulus with a scoreboard.
`default_nettype none

// Predicts update results and checks them in arrival order
class update_scoreboard;
  logic [23:0] lr;
  logic [16:0] disc;
  logic [15:0] eps;
  logic [31:0] ms_mem [1024];
  logic [9:0]  exp_index [$];
  logic [31:0] exp_weight [$];
  logic        exp_sat [$];
  int          errors;

  function new();
    lr = 24'd655;
    disc = 17'd58982;
    eps = 16'd1;
    foreach (ms_mem[i]) ms_mem[i] = rmsp_pkg::MsOne;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [23:0] data);
    case (idx)
      rmsp_pkg::RegLr:   lr = data;
      rmsp_pkg::RegDisc: disc = data[16:0];
      rmsp_pkg::RegEps:  eps = data[15:0];
      default: ;
    endcase
  endfunction

  static function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Works out the update for one accepted element
  function void note_element(logic [9:0] idx, logic [31:0] g, logic [31:0] w);
    logic        neg;
    logic [63:0] mag, gsq, d, ms_n, den, stp;
    logic signed [63:0] nw;
    logic        sat;
    neg = g[31];
    mag = neg ? (64'd1 << 32) - {32'd0, g} : {32'd0, g};
    d = (disc > 17'd65536) ? 64'd65536 : {47'd0, disc};
    gsq = (mag * mag) >> 16;
    ms_n = (d * ms_mem[idx] + (64'd65536 - d) * gsq) >> 16;
    sat = 0;
    if (ms_n > 64'hFFFF_FFFF) begin
      ms_n = 64'hFFFF_FFFF;
      sat = 1;
    end
    ms_mem[idx] = ms_n[31:0];
    den = int_sqrt(ms_n << 16) + eps;
    if (den == 0) den = 1;
    stp = (lr * mag) / den;
    nw = $signed({{32{w[31]}}, w});
    nw = neg ? nw + $signed(stp) : nw - $signed(stp);
    if (nw > 64'sh7FFF_FFFF) begin
      nw = 64'sh7FFF_FFFF;
      sat = 1;
    end else if (nw < -64'sh8000_0000) begin
      nw = -64'sh8000_0000;
      sat = 1;
    end
    exp_index = {exp_index, idx};
    exp_weight = {exp_weight, nw[31:0]};
    exp_sat = {exp_sat, sat};
  endfunction

  function void check_result(logic [9:0] idx, logic [31:0] nw, logic sat);
    if (exp_index.size() == 0) begin
      $display("%0t: unexpected result index %0d", $time, idx);
      errors++;
      return;
    end
    if (idx !== exp_index[0] || nw !== exp_weight[0] || sat !== exp_sat[0]) begin
      $display("%0t: mismatch expected idx %0d w %h sat %b actual idx %0d w %h sat %b",
               $time, exp_index[0], exp_weight[0], exp_sat[0], idx, nw, sat);
      errors++;
    end
    void'(exp_index.pop_front());
    void'(exp_weight.pop_front());
    void'(exp_sat.pop_front());
  endfunction

  function int pending();
    return exp_index.size();
  endfunction
endclass

module rmsprop_weight_update_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  update_scoreboard sb;
  int send_idle = 24;
  int recv_idle = 76;
  bit hold_recv = 0;
  longint cycles = 0;
  localparam longint CycleLimit = 2_000_000;

  rmsprop_weight_update_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: sample at rising edge, drive ready at falling edge
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[9:0], m_axis_tdata[41:10], m_axis_tuser[0]);

  always @(negedge clk_i)
    m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);

  task automatic write_cfg(logic [1:0] idx, logic [23:0] data);
    @(negedge clk_i);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid <= 0;
  endtask

  // Offers one element, with random idle cycles before it
  task automatic send_element(logic [9:0] idx, logic [31:0] g, logic [31:0] w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'd0, w, g, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_element(idx, g, w);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  // Most items revisit a few elements so the mean square evolves
  task automatic random_phase(int n);
    logic [9:0] idx;
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(7));
      send_element(idx, rand_value(), rand_value());
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // Directed: field extremes at reset settings
    send_element(10'd0, 32'd0, 32'd0);
    send_element(10'd1023, 32'h7FFF_FFFF, 32'h8000_0000);
    send_element(10'd1023, 32'h8000_0000, 32'h7FFF_FFFF);
    send_element(10'd5, 32'h0001_0000, 32'h0001_0000);
    send_element(10'd5, 32'hFFFF_0000, 32'hFFFF_FFFF);
    drain();
    // Large step, discount above one, maximal epsilon; then zero epsilon with zero mean square
    write_cfg(rmsp_pkg::RegLr, 24'hFF_FFFF);
    write_cfg(rmsp_pkg::RegDisc, 24'h1_FFFF);
    write_cfg(rmsp_pkg::RegEps, 24'hFFFF);
    send_element(10'd7, 32'h8000_0000, 32'h8000_0000);
    send_element(10'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();
    write_cfg(rmsp_pkg::RegDisc, 24'd0);
    write_cfg(rmsp_pkg::RegEps, 24'd0);
    send_element(10'd9, 32'd0, 32'h1234_5678);
    send_element(10'd9, 32'd0, 32'h1234_5678);
    send_element(10'd9, 32'h0000_0100, 32'h8000_0001);
    drain();
    // Unknown register index does nothing; then unit discount with zero learning rate
    write_cfg(2'd3, 24'hAB_CDEF);
    write_cfg(rmsp_pkg::RegDisc, 24'd65536);
    write_cfg(rmsp_pkg::RegLr, 24'd0);
    send_element(10'd9, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    drain();

    // Random phases under different settings and idling
    write_cfg(rmsp_pkg::RegLr, 24'd655);
    write_cfg(rmsp_pkg::RegDisc, 24'd58982);
    write_cfg(rmsp_pkg::RegEps, 24'd1);
    random_phase(250);
    drain();
    send_idle = 76;
    recv_idle = 24;
    write_cfg(rmsp_pkg::RegLr, 24'($urandom));
    write_cfg(rmsp_pkg::RegDisc, 24'($urandom_range(65536)));
    write_cfg(rmsp_pkg::RegEps, 24'($urandom_range(65535, 1)));
    random_phase(250);
    drain();
    send_idle = 0;
    recv_idle = 0;
    write_cfg(rmsp_pkg::RegLr, 24'h01_0000);
    write_cfg(rmsp_pkg::RegDisc, 24'd32768);
    // Long receiver hold-off fills the pipe and stalls the input
    fork
      begin
        hold_recv = 1;
        repeat (400) @(posedge clk_i);
        hold_recv = 0;
      end
      random_phase(250);
    join
    drain();

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
